>>> hw/rtl/mted_pkg.sv
// mted_pkg: shared types, constants and helpers for the threshold event duration block
// no dependencies
package mted_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 13;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = CNT_W + PCT_W;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic signed [SAMPLE_W-1:0] CUT_LINE_RST   = -16'sd256;
    localparam logic signed [SAMPLE_W-1:0] UNDEF_CODE_RST = -16'sd32768;
    localparam logic [PCT_W-1:0]           MIN_PCT_RST    = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUT_LINE  = 2'd0,
        CFG_UNDEF     = 2'd1,
        CFG_MIN_PCT   = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_VALUE        = 2'd0,
        ST_INSUFFICIENT = 2'd1,
        ST_NO_EVENT     = 2'd2,
        ST_BAD_CONFIG   = 2'd3
    } status_t;

    typedef struct packed {
        logic [CNT_W-1:0] run_length;
        logic             in_run;
        logic             crossed;
        logic [CNT_W-1:0] event_count;
        logic [CNT_W-1:0] valid_count;
        logic [CNT_W-1:0] sample_count;
        logic [CNT_W-1:0] best_length;
    } series_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

    // x * 100 as shifts and adds
    function automatic logic [PROD_W-1:0] times_100(input logic [CNT_W-1:0] c);
        logic [PROD_W-1:0] w;
        w = PROD_W'(c);
        return (w << 6) + (w << 5) + (w << 2);
    endfunction

endpackage

>>> hw/rtl/max_threshold_event_duration_top.sv
// max_threshold_event_duration_top: longest threshold-crossing run over a sample series
// depends on mted_pkg
//
// usage:
//   s_ channel carries one signed q8.8 sample per word in s_tdata, s_tlast marks the
//   final sample of a series. every word updates run length, event, valid and sample
//   counters; words equal to the undefined code only advance the sample count.
//   on the word with s_tlast one result word leaves on the m_ channel: duration in
//   m_tdata[12:0], status in m_tdata[14:13] (value, insufficient data, no event,
//   cut line zero). all series state then clears for the next series.
//   a word is first captured in the input register; when it is processed, a last word
//   loads its result into the result register, which drives m_tdata.
//   throughput: one word per cycle unless a last word waits on a held result; the
//   input register and the result register let a new word enter while a result waits.
//   when the receiver stalls with a result held, a further last word waits in the
//   input register and s_tready drops; non-last words keep flowing.
//   reset (aresetn low, synchronous) clears all series state and loads the default
//   registers: cut line -1.0, undefined code -32768, min valid percent 0.
//   configuration writes via cfg_wr_en/cfg_index/cfg_wdata take effect at the next edge.
module max_threshold_event_duration_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mted_pkg::S_TDATA_W-1:0]    s_tdata,   // sample[15:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mted_pkg::M_TDATA_W-1:0]    m_tdata,   // duration[12:0], status[14:13], zero[15]
    input  logic                              cfg_wr_en,
    input  logic [mted_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mted_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mted_pkg::*;

    logic signed [SAMPLE_W-1:0] cut_line_reg;
    logic signed [SAMPLE_W-1:0] undef_code_reg;
    logic [PCT_W-1:0]           min_pct_reg;

    logic                       in_v_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;

    series_t                    ser_reg, ser_next;

    logic                       m_v_reg;
    logic [CNT_W-1:0]           m_duration_reg, m_duration_next;
    status_t                    m_status_reg, m_status_next;

    logic                       fire;

    assign fire     = in_v_reg && (!in_last_reg || !m_v_reg || m_tready);
    assign s_tready = !in_v_reg || fire;
    assign m_tvalid = m_v_reg;
    assign m_tdata  = {1'b0, m_status_reg, m_duration_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cut_line_reg   <= CUT_LINE_RST;
            undef_code_reg <= UNDEF_CODE_RST;
            min_pct_reg    <= MIN_PCT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CUT_LINE: cut_line_reg   <= cfg_wdata[SAMPLE_W-1:0];
                CFG_UNDEF:    undef_code_reg <= cfg_wdata[SAMPLE_W-1:0];
                CFG_MIN_PCT:  min_pct_reg    <= cfg_wdata[PCT_W-1:0];
                CFG_UNUSED:   ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    // series update and result
    always_comb begin
        series_t           st;
        logic              valid;
        logic              cut_zero;
        logic              neg;
        logic              join_run;
        logic              reach;
        logic              stop;
        logic [PROD_W-1:0] valid_x100;
        logic [PROD_W-1:0] pct_x_count;

        st       = ser_reg;
        valid    = (in_sample_reg != undef_code_reg);
        cut_zero = (cut_line_reg == '0);
        neg      = cut_line_reg[SAMPLE_W-1];
        join_run = neg ? (in_sample_reg <= 0) : (in_sample_reg >= 0);
        reach    = neg ? (in_sample_reg <= cut_line_reg) : (in_sample_reg >= cut_line_reg);
        stop     = neg ? (in_sample_reg >= 0) : (in_sample_reg <= 0);

        st.sample_count = sat_inc(st.sample_count);
        if (valid) begin
            if (!cut_zero) begin
                if (join_run) begin
                    st.in_run = 1'b1;
                    if (reach && !st.crossed) begin
                        st.crossed     = 1'b1;
                        st.event_count = sat_inc(st.event_count);
                    end
                    st.run_length = sat_inc(st.run_length);
                end
                if (stop && st.in_run) begin
                    if (st.crossed && st.run_length > st.best_length) begin
                        st.best_length = st.run_length;
                    end
                    st.in_run     = 1'b0;
                    st.crossed    = 1'b0;
                    st.run_length = '0;
                end
            end
            st.valid_count = sat_inc(st.valid_count);
        end

        if (!cut_zero && st.in_run && st.crossed && st.run_length > st.best_length) begin
            st.best_length = st.run_length;
        end

        valid_x100  = times_100(st.valid_count);
        pct_x_count = PROD_W'(min_pct_reg) * PROD_W'(st.sample_count);

        m_duration_next = '0;
        priority if (cut_zero) begin
            m_status_next = ST_BAD_CONFIG;
        end else if (valid_x100 <= pct_x_count) begin
            m_status_next = ST_INSUFFICIENT;
        end else if (st.event_count == '0) begin
            m_status_next = ST_NO_EVENT;
        end else begin
            m_status_next   = ST_VALUE;
            m_duration_next = st.best_length;
        end

        ser_next = in_last_reg ? '0 : st;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_reg <= '0;
        end else if (fire) begin
            ser_reg <= ser_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            m_v_reg <= 1'b1;
        end else if (m_tready) begin
            m_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) begin
            m_duration_reg <= m_duration_next;
            m_status_reg   <= m_status_next;
        end
    end

endmodule

>>> tb/sv/mted_series_sb_pkg.sv
// mted_series_sb_pkg: scoreboard for the threshold event duration testbench, predicts
// one duration/status word per series from accepted samples and register writes
// depends on mted_pkg
package mted_series_sb_pkg;

    import mted_pkg::*;

    typedef struct {
        logic [CNT_W-1:0] duration;
        status_t          status;
    } outcome_t;

    class series_scoreboard;
        logic signed [SAMPLE_W-1:0] cut_line;
        logic signed [SAMPLE_W-1:0] undef_code;
        logic [PCT_W-1:0]           min_pct;
        logic [CNT_W-1:0]           run_len;
        logic [CNT_W-1:0]           event_cnt;
        logic [CNT_W-1:0]           valid_cnt;
        logic [CNT_W-1:0]           sample_cnt;
        logic [CNT_W-1:0]           best_len;
        bit                         in_run;
        bit                         crossed;
        outcome_t                   outcome_q[$];
        int                         errors;

        function new();
            cut_line   = CUT_LINE_RST;
            undef_code = UNDEF_CODE_RST;
            min_pct    = MIN_PCT_RST;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            run_len    = '0;
            in_run     = 1'b0;
            crossed    = 1'b0;
            event_cnt  = '0;
            valid_cnt  = '0;
            sample_cnt = '0;
            best_len   = '0;
        endfunction

        function logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
            return (&c) ? c : c + 1'b1;
        endfunction

        function void keep_longest();
            if (crossed && run_len > best_len) begin
                best_len = run_len;
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void set_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CUT_LINE: begin
                    cut_line = data[SAMPLE_W-1:0];
                end
                CFG_UNDEF: begin
                    undef_code = data[SAMPLE_W-1:0];
                end
                CFG_MIN_PCT: begin
                    min_pct = data[PCT_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
            bit       neg;
            bit       joins;
            bit       reaches;
            bit       stops;
            outcome_t res;
            sample_cnt = count_up(sample_cnt);
            if (smp != undef_code) begin
                if (cut_line != 0) begin
                    neg     = cut_line < 0;
                    joins   = neg ? (smp <= 0) : (smp >= 0);
                    reaches = neg ? (smp <= cut_line) : (smp >= cut_line);
                    stops   = neg ? (smp >= 0) : (smp <= 0);
                    if (joins) begin
                        in_run = 1'b1;
                        if (reaches && !crossed) begin
                            crossed   = 1'b1;
                            event_cnt = count_up(event_cnt);
                        end
                        run_len = count_up(run_len);
                    end
                    // a zero sample joins the run and closes it in the same word
                    if (stops && in_run) begin
                        in_run = 1'b0;
                        keep_longest();
                        crossed = 1'b0;
                        run_len = '0;
                    end
                end
                valid_cnt = count_up(valid_cnt);
            end
            if (!lst) begin
                return;
            end
            if (cut_line != 0 && in_run) begin
                keep_longest();
            end
            res.duration = '0;
            if (cut_line == 0) begin
                res.status = ST_BAD_CONFIG;
            end else if (int'(valid_cnt) * 100 <= int'(min_pct) * int'(sample_cnt)) begin
                res.status = ST_INSUFFICIENT;
            end else if (event_cnt == 0) begin
                res.status = ST_NO_EVENT;
            end else begin
                res.status   = ST_VALUE;
                res.duration = best_len;
            end
            outcome_q.push_back(res);
            restart();
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] word);
            outcome_t         want;
            logic [CNT_W-1:0] dur;
            logic [1:0]       st;
            dur = word[CNT_W-1:0];
            st  = word[CNT_W+1:CNT_W];
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: unexpected result word %h", $time, word);
                end
                return;
            end
            want = outcome_q.pop_front();
            if (dur !== want.duration || st !== want.status
                    || word[M_TDATA_W-1:CNT_W+2] !== '0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: result mismatch, expected duration %0d status %s, got %0d %0d pad %b",
                             $time, want.duration, want.status.name(), dur, st,
                             word[M_TDATA_W-1:CNT_W+2]);
                end
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb.sv
// tb: top of the threshold event duration testbench, drives sample series and register
// writes into max_threshold_event_duration_top and checks every result word
// depends on mted_pkg, mted_series_sb_pkg and the block's rtl
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mted_pkg::*;
    import mted_series_sb_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 950;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    logic                    hold_req;
    bit                      src_burst;
    int                      words_sent;
    int                      stall_cycles = 0;
    series_scoreboard        sb = new();

    always #6 aclk = ~aclk;

    max_threshold_event_duration_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        int hold;
        bit sink_burst;
        bit hold_taken;
        gap        = 0;
        hold       = 0;
        sink_burst = 1'b0;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                if ($urandom_range(0, 15) == 0) begin
                    sink_burst = !sink_burst;
                end
                gap = sink_burst ? 0 : $urandom_range(0, 4);
            end else if (gap > 0) begin
                gap--;
            end
            if (hold_req && !hold_taken) begin
                hold       = HOLD_CYCLES;
                hold_taken = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end
            m_tready <= (gap == 0 && hold == 0);
        end
    end

    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp, lst);
        words_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_register(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        int span;
        int mag;
        roll = $urandom_range(0, 99);
        span = (sb.cut_line < 0) ? -int'(sb.cut_line) : int'(sb.cut_line);
        if (span == 0) begin
            span = 256;
        end
        mag = $urandom_range(0, (span > 16383) ? 32767 : 2 * span);
        if (roll < 12) begin
            return sb.undef_code;
        end
        if (roll < 20) begin
            return '0;
        end
        if (roll < 35) begin
            return sb.cut_line + SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
        end
        if (roll < 75) begin
            return (sb.cut_line < 0) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
        end
        if (roll < 88) begin
            return (sb.cut_line < 0) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
        end
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_series(input int len);
        for (int i = 0; i < len; i++) begin
            send_word(pick_sample(), i == len - 1);
        end
    endtask

    task automatic shuffle_registers();
        logic [CFG_DATA_W-1:0] data;
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 11))
                0: data = 16'h8000;
                1: data = 16'h7FFF;
                2: data = 16'hFFFF;
                3: data = 16'h0001;
                4: data = '0;
                5, 6: data = CFG_DATA_W'(-int'($urandom_range(1, 2048)));
                7, 8: data = CFG_DATA_W'($urandom_range(1, 2048));
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_CUT_LINE, data);
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
                0: data = 16'h8000;
                1: data = 16'h7FFF;
                2: data = '0;
                3: data = sb.cut_line;
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_UNDEF, data);
        end
        if ($urandom_range(0, 2) == 0) begin
            data = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 5))
                0: data[PCT_W-1:0] = '0;
                1: data[PCT_W-1:0] = 7'd100;
                2: data[PCT_W-1:0] = 7'd127;
                default: data[PCT_W-1:0] = PCT_W'($urandom_range(0, 60));
            endcase
            write_reg(CFG_MIN_PCT, data);
        end
        if ($urandom_range(0, 9) == 0) begin
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        end
    endtask

    initial begin : stimulus
        int  start;
        bit  held;
        held       = 1'b0;
        words_sent = 0;
        src_burst  = 1'b0;
        hold_req  <= 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_CUT_LINE;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: negative runs, extremes, exact cut, zero closing a run
        send_word(16'h8000, 1'b0);
        send_word(-16'sd256, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word('0, 1'b0);
        send_word(-16'sd300, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(-16'sd32767, 1'b0);
        send_word(-16'sd5, 1'b1);
        // no run reaches the cut
        send_word(-16'sd1, 1'b0);
        send_word(-16'sd255, 1'b1);

        drain_results();
        write_reg(CFG_CUT_LINE, 16'd256);
        send_word(16'sd256, 1'b0);
        send_word('0, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(-16'sd1, 1'b1);

        drain_results();
        write_reg(CFG_CUT_LINE, '0);
        send_word(16'sd3, 1'b0);
        send_word(-16'sd3, 1'b1);

        // percent above 100, upper write bits dropped
        drain_results();
        write_reg(CFG_CUT_LINE, CUT_LINE_RST);
        write_reg(CFG_MIN_PCT, 16'hFFFF);
        send_word(-16'sd500, 1'b1);

        drain_results();
        write_reg(CFG_MIN_PCT, 16'd50);
        write_reg(CFG_UNDEF, '0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_word('0, 1'b0);
        send_word(-16'sd300, 1'b0);
        send_word(16'sd5, 1'b1);
        send_word('0, 1'b1);

        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            drain_results();
            shuffle_registers();
            src_burst = ($urandom_range(0, 3) == 0);
            if (!held && words_sent - start > RANDOM_WORDS / 2) begin
                held      = 1'b1;
                src_burst = 1'b1;
                hold_req <= 1'b1;
                repeat (40) send_series($urandom_range(1, 3));
            end
            repeat ($urandom_range(1, 6)) begin
                send_series(($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                        : $urandom_range(1, 12));
            end
            // leave a series open across the next register change
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 5)) send_word(pick_sample(), 1'b0);
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mted_pkg.sv
hw/rtl/max_threshold_event_duration_top.sv
tb/sv/mted_series_sb_pkg.sv
tb/sv/tb.sv
